[hw/rtl/mpc_pkg.sv]
// ----------------------------------------------------------------------------
// Mandelbrot colouring package
// Shared types and constants for the escape-time pixel colouring unit.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int DATA_BITS  = 32;
  localparam int COUNT_BITS = 16;
  localparam int COLOR_BITS = 24;

  localparam logic [2:0] REG_REAL_START = 3'd0;
  localparam logic [2:0] REG_REAL_STEP  = 3'd1;
  localparam logic [2:0] REG_IMAG_START = 3'd2;
  localparam logic [2:0] REG_IMAG_STEP  = 3'd3;
  localparam logic [2:0] REG_ITER_LIMIT = 3'd4;

  localparam logic [7:0] GREY_LEVEL   = 8'd150;
  localparam logic [7:0] HUE_OFFSET   = 8'd200;
  localparam logic [7:0] WHEEL_SECTOR = 8'd43;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] cr;
    logic signed [DATA_BITS-1:0] ci;
  } point_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] colour;
    logic [COUNT_BITS-1:0] count;
  } result_t;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [DATA_BITS-1:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return v[DATA_BITS-1:0];
  endfunction

  // HSV wheel, full saturation and value; packed b,g,r.
  function automatic logic [COLOR_BITS-1:0] wheel(input logic [7:0] h);
    logic [2:0]  region;
    logic [8:0]  rem;
    logic [16:0] a;
    logic [16:0] b;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [7:0]  rr;
    logic [7:0]  gg;
    logic [7:0]  bb;
    if (h < 8'd43) region = 3'd0;
    else if (h < 8'd86) region = 3'd1;
    else if (h < 8'd129) region = 3'd2;
    else if (h < 8'd172) region = 3'd3;
    else if (h < 8'd215) region = 3'd4;
    else region = 3'd5;
    rem = 9'((h - 8'(region * WHEEL_SECTOR)) * 6);
    a = 17'(17'd255 * rem);
    q = 8'((17'd255 * (17'd255 - 17'(a[16:8]))) >> 8);
    b = 17'(17'd255 * (17'd255 - 17'(rem)));
    t = 8'((17'd255 * (17'd255 - 17'(b[16:8]))) >> 8);
    case (region)
      3'd0: begin rr = 8'd255; gg = t; bb = 8'd0; end
      3'd1: begin rr = q; gg = 8'd255; bb = 8'd0; end
      3'd2: begin rr = 8'd0; gg = 8'd255; bb = t; end
      3'd3: begin rr = 8'd0; gg = q; bb = 8'd255; end
      3'd4: begin rr = t; gg = 8'd0; bb = 8'd255; end
      default: begin rr = 8'd255; gg = 8'd0; bb = q; end
    endcase
    return {bb, gg, rr};
  endfunction

endpackage

[hw/rtl/mpc_stream_if.sv]
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload of parameterized width.
// ----------------------------------------------------------------------------
interface mpc_stream_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mandelbrot_pixel_colouring_unit.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel colouring unit
// Escape-time iteration of one pixel and HSV colouring of its count.
// ----------------------------------------------------------------------------
// Usage: send a pixel (column, row) on the in channel; one item comes back on
// the out channel with the packed B,G,R colour and the iteration count.
// The front end registers the pixel, forms the step products and then the
// saturated c, which it hands to the back end through a one-entry register,
// so the next pixel can be mapped while the back end still iterates. The
// back end does one complex step per cycle, then a 16-step division for the
// hue (skipped when the limit's low byte is zero), then registers the colour
// and offers the result, count being at most iteration_limit (default 500).
// The back end works on one point at a time; this escape loop sets the
// throughput.
// Configuration writes (cfg_*) are taken at once; write them only when idle.
// Reset restores the default view and limit and empties both ends.
// A stalled receiver holds the result; the back end then takes no new point.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_colouring_unit #(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  mpc_stream_if.sink   in_if,
  mpc_stream_if.source out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mpc_pkg::*;

  logic signed [31:0] real_start_r;
  logic signed [31:0] real_step_r;
  logic signed [31:0] imag_start_r;
  logic signed [31:0] imag_step_r;
  logic [15:0]        limit_r;
  logic               pt_valid;
  logic               pt_ready;
  point_t             pt_data;
  result_t            res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_start_r <= -32'sd671088640;
      real_step_r  <= 32'sd1468006;
      imag_start_r <= -32'sd268435456;
      imag_step_r  <= 32'sd1118481;
      limit_r      <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REAL_START: real_start_r <= cfg_data;
        REG_REAL_STEP:  real_step_r  <= cfg_data;
        REG_IMAG_START: imag_start_r <= cfg_data;
        REG_IMAG_STEP:  imag_step_r  <= cfg_data;
        REG_ITER_LIMIT: limit_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mpc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .in_column(in_if.data[COORD_BITS-1:0]),
    .in_row(in_if.data[2*COORD_BITS-1:COORD_BITS]),
    .real_start(real_start_r), .real_step(real_step_r),
    .imag_start(imag_start_r), .imag_step(imag_step_r),
    .pt_valid, .pt_ready, .pt_data
  );

  mpc_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .pt_valid, .pt_ready, .pt_data, .limit(limit_r),
    .res_valid(out_if.valid), .res_ready(out_if.ready), .res_data(res)
  );

  assign out_if.data = res;

`ifndef ASSERT_OFF
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> res.count <= limit_r)
    else $error("count above limit");
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && res.count[7:0] == limit_r[7:0]) |->
      res.colour == {GREY_LEVEL, GREY_LEVEL, GREY_LEVEL})
    else $error("equal bytes not grey");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pt_valid && !pt_ready) |=> pt_valid)
    else $error("point dropped");
`endif
endmodule

[hw/rtl/mpc_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accepts a pixel, registers the step products and maps them to a saturated complex point.
// ----------------------------------------------------------------------------
module mpc_front #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [COORD_BITS-1:0] in_column,
  input  logic [COORD_BITS-1:0] in_row,
  input  logic signed [31:0] real_start,
  input  logic signed [31:0] real_step,
  input  logic signed [31:0] imag_start,
  input  logic signed [31:0] imag_step,
  output logic pt_valid,
  input  logic pt_ready,
  output mpc_pkg::point_t pt_data
);
  import mpc_pkg::*;

  logic                  busy_r;
  logic                  prod_r;
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;
  logic signed [47:0]    pr_r;
  logic signed [47:0]    pi_r;
  point_t                pt_r;
  logic                  pt_valid_r;
  logic signed [33:0]    sr;
  logic signed [33:0]    si;
  logic                  pt_load;

  assign in_ready = !busy_r;
  assign pt_valid = pt_valid_r;
  assign pt_data  = pt_r;
  assign pt_load  = busy_r && prod_r && (!pt_valid_r || pt_ready);

  // products are bounded by 2^43, a 34-bit sum saturates correctly after clamp
  always_comb begin
    sr = 34'(48'(real_start) + ((pr_r > 48'sd4294967295) ? 48'sd4294967295 :
         (pr_r < -48'sd4294967296) ? -48'sd4294967296 : pr_r));
    si = 34'(48'(imag_start) + ((pi_r > 48'sd4294967295) ? 48'sd4294967295 :
         (pi_r < -48'sd4294967296) ? -48'sd4294967296 : pi_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      prod_r     <= 1'b0;
      pt_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        col_r  <= in_column;
        row_r  <= in_row;
        busy_r <= 1'b1;
        prod_r <= 1'b0;
      end else if (busy_r && !prod_r) begin
        pr_r   <= 48'($signed({1'b0, col_r}) * real_step);
        pi_r   <= 48'($signed({1'b0, row_r}) * imag_step);
        prod_r <= 1'b1;
      end else if (pt_load) begin
        pt_r.cr <= sat34(sr);
        pt_r.ci <= sat34(si);
        busy_r  <= 1'b0;
      end
      // drop the handed-over point unless a new one replaces it
      if (pt_load) begin
        pt_valid_r <= 1'b1;
      end else if (pt_valid_r && pt_ready) begin
        pt_valid_r <= 1'b0;
      end
    end
  end
endmodule

[hw/rtl/mpc_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Iterates z = z*z + c, one complex step per cycle, then colours the count.
// ----------------------------------------------------------------------------
module mpc_back #(
  parameter int FRACTION_BITS = 28
) (
  input  logic clk,
  input  logic rst_n,
  input  logic pt_valid,
  output logic pt_ready,
  input  mpc_pkg::point_t pt_data,
  input  logic [15:0] limit,
  output logic res_valid,
  input  logic res_ready,
  output mpc_pkg::result_t res_data
);
  import mpc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ITER, S_DIV, S_COLOR, S_OUT} state_t;

  state_t             state_r;
  point_t             c_r;
  logic signed [31:0] zr_r;
  logic signed [31:0] zi_r;
  logic [15:0]        count_r;
  logic [7:0]         rem_r;
  logic [15:0]        dvd_r;
  logic [7:0]         quot_r;
  logic [4:0]         bit_r;
  result_t            res_r;
  logic signed [63:0] zrr;
  logic signed [63:0] zii;
  logic signed [63:0] zri;
  logic signed [63:0] zr2;
  logic signed [63:0] zi2;
  logic signed [63:0] zx;
  logic signed [63:0] sum;
  logic               escape;
  logic [9:0]         trial;
  logic [7:0]         lim_b;
  logic [7:0]         cnt_b;
  logic [7:0]         hue;

  assign pt_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_data  = res_r;
  assign lim_b     = limit[7:0];
  assign cnt_b     = count_r[7:0];

  always_comb begin
    zrr    = zr_r * zr_r;
    zii    = zi_r * zi_r;
    zri    = zr_r * zi_r;
    zr2    = zrr >>> FRACTION_BITS;
    zi2    = zii >>> FRACTION_BITS;
    zx     = zri >>> (FRACTION_BITS - 1);
    sum    = zr2 + zi2;
    escape = sum > (64'sd4 <<< FRACTION_BITS);
    trial  = {1'b0, rem_r, dvd_r[15]} - {2'b00, lim_b};
    hue    = 8'(8'd255 - quot_r + HUE_OFFSET);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pt_valid) begin
            c_r     <= pt_data;
            zr_r    <= '0;
            zi_r    <= '0;
            count_r <= '0;
            state_r <= S_ITER;
          end
        end
        S_ITER: begin
          if (count_r >= limit || escape) begin
            // restoring division of the count's low byte * 255 by the limit byte, 16 steps
            rem_r   <= '0;
            dvd_r   <= 16'(cnt_b) * 16'd255;
            quot_r  <= '0;
            bit_r   <= 5'd16;
            state_r <= S_DIV;
          end else begin
            zr_r    <= sat34(34'(zr2 - zi2 + 64'(c_r.cr)));
            zi_r    <= sat34(34'(zx + 64'(c_r.ci)));
            count_r <= count_r + 16'd1;
          end
        end
        S_DIV: begin
          if (lim_b == 8'd0 || bit_r == 5'd0) begin
            state_r <= S_COLOR;
          end else begin
            // shift in the next dividend bit, subtract the limit byte if it fits
            if (!trial[9]) begin
              rem_r  <= trial[7:0];
              quot_r <= {quot_r[6:0], 1'b1};
            end else begin
              rem_r  <= {rem_r[6:0], dvd_r[15]};
              quot_r <= {quot_r[6:0], 1'b0};
            end
            dvd_r <= {dvd_r[14:0], 1'b0};
            bit_r <= bit_r - 5'd1;
          end
        end
        S_COLOR: begin
          res_r.count  <= count_r;
          res_r.colour <= (cnt_b == lim_b) ? {GREY_LEVEL, GREY_LEVEL, GREY_LEVEL}
                                           : wheel(hue);
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
